// ----- hw/rtl/message_latency_statistics_top_defines.svh -----
// assertion macros used by the checker file
`ifndef MESSAGE_LATENCY_STATISTICS_TOP_DEFINES_SVH
`define MESSAGE_LATENCY_STATISTICS_TOP_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MLS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("message statistics check failed");

// next-cycle implication, disabled while in reset
`define MLS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("message statistics check failed");

`endif

// ----- hw/rtl/mls_pkg.sv -----
package mls_pkg;

  localparam int unsigned CNT_W = 32;
  localparam int unsigned SUM_W = 64;

  // item kinds
  typedef enum logic [2:0] {
    KIND_CREATE     = 3'd0,
    KIND_INJECT     = 3'd1,
    KIND_RECEIVE    = 3'd2,
    KIND_READ_HIST  = 3'd3,
    KIND_READ_CLASS = 3'd4,
    KIND_READ_SCR   = 3'd5
  } mls_kind_e;

  // control from the sequencer to the bin memories
  typedef struct packed {
    logic rd;
    logic wr;
    logic hist_inc;
    logic scr_inc;
  } mls_bins_ctrl_t;

  // status from the bin memories
  typedef struct packed {
    logic clearing;
  } mls_bins_stat_t;

endpackage

// ----- hw/rtl/mls_ram.sv -----
module mls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/mls_bins.sv -----
module mls_bins #(
  parameter int unsigned HIST_BINS  = 4096,
  parameter int unsigned CLASS_BINS = 21
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mls_pkg::mls_bins_ctrl_t       ctrl_i,
  input  logic [$clog2(HIST_BINS)-1:0]  hist_addr_i,
  input  logic [$clog2(CLASS_BINS)-1:0] class_addr_i,
  output logic [mls_pkg::CNT_W-1:0]     hist_data_o,
  output logic [mls_pkg::CNT_W-1:0]     class_data_o,
  output logic [mls_pkg::CNT_W-1:0]     scr_data_o,
  output mls_pkg::mls_bins_stat_t       stat_o
);
  import mls_pkg::*;

  localparam int unsigned HB_W      = $clog2(HIST_BINS);
  localparam int unsigned CB_W      = $clog2(CLASS_BINS);
  localparam int unsigned CLR_DEPTH = (HIST_BINS > CLASS_BINS) ? HIST_BINS : CLASS_BINS;
  localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);

  logic [HB_W-1:0]    hist_addr_q;
  logic [CB_W-1:0]    class_addr_q;
  logic [CLR_W-1:0]   clr_q;
  logic               clearing_q;

  logic               hist_we;
  logic [HB_W-1:0]    hist_waddr;
  logic [CNT_W-1:0]   hist_wdata;
  logic               class_we;
  logic [CB_W-1:0]    class_waddr;
  logic [2*CNT_W-1:0] class_wdata;
  logic [2*CNT_W-1:0] class_rdata;

  // address capture for the write-back
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      hist_addr_q  <= hist_addr_i;
      class_addr_q <= class_addr_i;
    end
  end

  // clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clearing_q <= 1'b1;
    end else if (clearing_q) begin
      if (32'(clr_q) == CLR_DEPTH - 1) begin
        clearing_q <= 1'b0;
      end else begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // write port muxing: sweep or increment
  always_comb begin
    if (clearing_q) begin
      hist_we     = 32'(clr_q) < HIST_BINS;
      hist_waddr  = clr_q[HB_W-1:0];
      hist_wdata  = '0;
      class_we    = 32'(clr_q) < CLASS_BINS;
      class_waddr = clr_q[CB_W-1:0];
      class_wdata = '0;
    end else begin
      hist_we     = ctrl_i.wr && ctrl_i.hist_inc;
      hist_waddr  = hist_addr_q;
      hist_wdata  = hist_data_o + 1'b1;
      class_we    = ctrl_i.wr;
      class_waddr = class_addr_q;
      class_wdata = {class_rdata[2*CNT_W-1:CNT_W] + CNT_W'(ctrl_i.scr_inc),
                     class_rdata[CNT_W-1:0] + 1'b1};
    end
  end

  // latency histogram
  mls_ram #(
    .WIDTH (CNT_W),
    .DEPTH (HIST_BINS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (ctrl_i.rd),
    .raddr_i (hist_addr_i),
    .rdata_o (hist_data_o)
  );

  // class counters, scratched in the upper half
  mls_ram #(
    .WIDTH (2 * CNT_W),
    .DEPTH (CLASS_BINS)
  ) u_class_ram (
    .clk_i   (clk_i),
    .we_i    (class_we),
    .waddr_i (class_waddr),
    .wdata_i (class_wdata),
    .re_i    (ctrl_i.rd),
    .raddr_i (class_addr_i),
    .rdata_o (class_rdata)
  );

  assign class_data_o    = class_rdata[CNT_W-1:0];
  assign scr_data_o      = class_rdata[2*CNT_W-1:CNT_W];
  assign stat_o.clearing = clearing_q;

endmodule

// ----- hw/rtl/message_latency_statistics_top.sv -----
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+----------------------------------
// item      | in        | start && !busy             | kind_i .. read_index_i
// config    | in        | cfg_valid_i && cfg_ready_o | cfg_logging_enable_i
// result    | out       | done_o (one cycle strobe)  | sent_count_o .. read_value_o
//
// each item passes through histogram/class memory read, latency square multiply,
// then the read-modify-write back into the memories; busy is low only in idle.
// the result strobe comes in the cycle after write-back; the receiver cannot stall.
// after reset a clearing sweep over max(HIST_BINS, CLASS_BINS) entries (4096 by
// default) zeroes the memories while busy stays high; config writes are taken.
module message_latency_statistics_top #(
  parameter int unsigned HIST_BINS  = 4096,
  parameter int unsigned CLASS_BINS = 21
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                kind_i,
  input  logic [31:0]               now_time_i,
  input  logic [31:0]               msg_start_time_i,
  input  logic [7:0]                msg_class_i,
  input  logic                      is_scratched_i,
  input  logic                      is_misrouted_i,
  input  logic [11:0]               read_index_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_logging_enable_i,
  output logic                      done_o,
  output logic [31:0]               sent_count_o,
  output logic [31:0]               injected_count_o,
  output logic [31:0]               received_count_o,
  output logic [63:0]               latency_total_o,
  output logic [63:0]               latency_square_total_o,
  output logic [63:0]               source_latency_total_o,
  output logic [31:0]               misrouted_count_o,
  output logic [31:0]               scratched_count_o,
  output logic [31:0]               read_value_o
);
  import mls_pkg::*;

  localparam int unsigned HB_W = $clog2(HIST_BINS);
  localparam int unsigned CB_W = $clog2(CLASS_BINS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_WB
  } state_e;

  state_e         state_q;
  logic           logging_q;
  logic           done_q;
  logic [CNT_W-1:0] read_value_q;
  logic [SUM_W-1:0] sq_q;
  logic [CNT_W-1:0] sent_q, injected_q, received_q, misrouted_q, scratched_q;
  logic [SUM_W-1:0] lat_sum_q, sq_sum_q, src_sum_q;

  mls_kind_e      kind_q;
  logic [CNT_W-1:0] delay_q;
  logic           scr_q;
  logic           mis_q;
  logic           hist_hit_q;
  logic           hist_ok_q;
  logic           class_ok_q;

  logic           accept;
  mls_kind_e      kind_in;
  logic [CNT_W-1:0] delay_in;
  logic [CNT_W-1:0] idx_in;
  logic [CB_W-1:0]  slot_in;
  logic [HB_W-1:0]  hist_addr;
  logic [CB_W-1:0]  class_addr;
  logic [SUM_W-1:0] sq_w;
  logic [CNT_W-1:0] read_value_w;
  logic [CNT_W-1:0] hist_data;
  logic [CNT_W-1:0] class_data;
  logic [CNT_W-1:0] scr_data;
  logic           wb_receive;

  mls_bins_ctrl_t bins_ctrl;
  mls_bins_stat_t bins_stat;

  assign busy        = bins_stat.clearing || (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // decode of the incoming item for the memory read
  assign kind_in  = mls_kind_e'(kind_i);
  assign delay_in = now_time_i - msg_start_time_i;
  assign idx_in   = CNT_W'(read_index_i);
  assign slot_in  = (32'(msg_class_i) >= CLASS_BINS - 1) ? CB_W'(CLASS_BINS - 1)
                                                          : msg_class_i[CB_W-1:0];
  always_comb begin
    if (kind_in == KIND_RECEIVE) begin
      hist_addr  = delay_in[HB_W-1:0];
      class_addr = slot_in;
    end else begin
      hist_addr  = idx_in[HB_W-1:0];
      class_addr = idx_in[CB_W-1:0];
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= kind_in;
      delay_q    <= delay_in;
      scr_q      <= is_scratched_i;
      mis_q      <= is_misrouted_i;
      hist_hit_q <= delay_in < HIST_BINS;
      hist_ok_q  <= idx_in < HIST_BINS;
      class_ok_q <= idx_in < CLASS_BINS;
    end
  end

  assign sq_w       = SUM_W'(delay_q) * SUM_W'(delay_q);
  assign wb_receive = (state_q == S_WB) && (kind_q == KIND_RECEIVE) && logging_q;

  // memory control
  assign bins_ctrl.rd       = accept;
  assign bins_ctrl.wr       = wb_receive;
  assign bins_ctrl.hist_inc = hist_hit_q;
  assign bins_ctrl.scr_inc  = scr_q;

  // entry selection for read kinds
  always_comb begin
    case (kind_q)
      KIND_READ_HIST:  read_value_w = hist_ok_q ? hist_data : '0;
      KIND_READ_CLASS: read_value_w = class_ok_q ? class_data : '0;
      KIND_READ_SCR:   read_value_w = class_ok_q ? scr_data : '0;
      default:         read_value_w = '0;
    endcase
  end

  // sequencer, counters and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      logging_q    <= 1'b1;
      done_q       <= 1'b0;
      read_value_q <= '0;
      sq_q         <= '0;
      sent_q       <= '0;
      injected_q   <= '0;
      received_q   <= '0;
      misrouted_q  <= '0;
      scratched_q  <= '0;
      lat_sum_q    <= '0;
      sq_sum_q     <= '0;
      src_sum_q    <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        logging_q <= cfg_logging_enable_i;
      end
      case (state_q)
        S_IDLE: begin
          done_q <= 1'b0;
          if (accept) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          sq_q    <= sq_w;
          state_q <= S_WB;
        end
        S_WB: begin
          if (logging_q) begin
            case (kind_q)
              KIND_CREATE: begin
                sent_q <= sent_q + 1'b1;
              end
              KIND_INJECT: begin
                injected_q <= injected_q + 1'b1;
                src_sum_q  <= src_sum_q + SUM_W'(delay_q);
              end
              KIND_RECEIVE: begin
                received_q  <= received_q + 1'b1;
                lat_sum_q   <= lat_sum_q + SUM_W'(delay_q);
                sq_sum_q    <= sq_sum_q + sq_q;
                misrouted_q <= misrouted_q + CNT_W'(mis_q);
                scratched_q <= scratched_q + CNT_W'(scr_q);
              end
              default: begin
              end
            endcase
          end
          read_value_q <= read_value_w;
          done_q       <= 1'b1;
          state_q      <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  mls_bins #(
    .HIST_BINS  (HIST_BINS),
    .CLASS_BINS (CLASS_BINS)
  ) u_bins (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (bins_ctrl),
    .hist_addr_i  (hist_addr),
    .class_addr_i (class_addr),
    .hist_data_o  (hist_data),
    .class_data_o (class_data),
    .scr_data_o   (scr_data),
    .stat_o       (bins_stat)
  );

  assign done_o                 = done_q;
  assign sent_count_o           = sent_q;
  assign injected_count_o       = injected_q;
  assign received_count_o       = received_q;
  assign latency_total_o        = lat_sum_q;
  assign latency_square_total_o = sq_sum_q;
  assign source_latency_total_o = src_sum_q;
  assign misrouted_count_o      = misrouted_q;
  assign scratched_count_o      = scratched_q;
  assign read_value_o           = read_value_q;

endmodule

// ----- hw/rtl/mls_checker.sv -----
`include "message_latency_statistics_top_defines.svh"

module mls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [31:0] sent_count_o
);

  // result is only shown once the block is back in idle
  `MLS_ASSERT_NOW(a_done_not_busy, done_o, !busy)
  // an accepted item keeps the block busy
  `MLS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // no result right after a transfer in
  `MLS_ASSERT_NEXT(a_accept_no_done, start && !busy, !done_o)
  // the sent counter changes only with a result
  `MLS_ASSERT_NOW(a_count_with_done, !$stable(sent_count_o), done_o)

endmodule

bind message_latency_statistics_top mls_checker u_mls_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .done_o       (done_o),
  .sent_count_o (sent_count_o)
);
